// ----- sv/ksrl_pkg.sv -----
// Package for key_set_with_rollback_log: opcodes, status codes, result word
// type and parameter defaults. No dependencies.
package ksrl_pkg;

  localparam int unsigned LOG_DEPTH_DEF = 256;
  localparam int unsigned KEY_BITS_DEF  = 64;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned MARK_W        = 9;
  localparam int unsigned COUNT_W       = 9;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_ROLLBACK = 1'b1;

  localparam logic [1:0] ST_PRESENT = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_ROLLED  = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic               done;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ----- sv/key_set_with_rollback_log.sv -----
// Key set with rollback log. An add word (op_i = 0) is taken when start is
// high and busy is low; busy then stays high while the log is scanned one
// live entry per cycle through the single read port of the log memory, and
// the scan ends early when the key is found. The result shows on done_o in
// the first cycle that busy is low again. A rollback word (op_i = 1) never
// raises busy and answers on done_o in the next cycle. Each result is valid
// for one cycle only and cannot be held off. Depends on ksrl_pkg, ksrl_ctrl,
// ksrl_log_mem.
module key_set_with_rollback_log #(
  parameter int unsigned LOG_DEPTH = ksrl_pkg::LOG_DEPTH_DEF,
  parameter int unsigned KEY_BITS  = ksrl_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [ksrl_pkg::KEY_W-1:0]   key_i,
  input  logic [ksrl_pkg::MARK_W-1:0]  mark_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [ksrl_pkg::COUNT_W-1:0] count_o
);

  localparam int unsigned AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;
  ksrl_pkg::result_t   res;

  ksrl_ctrl #(
    .LOG_DEPTH (LOG_DEPTH),
    .KEY_BITS  (KEY_BITS),
    .AW        (AW),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .key_i       (key_i),
    .mark_i      (mark_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  ksrl_log_mem #(
    .DEPTH (LOG_DEPTH),
    .WIDTH (KEY_BITS),
    .AW    (AW)
  ) u_log_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign done_o   = res.done;
  assign status_o = res.status;
  assign count_o  = res.count;

`ifndef SYNTH
  a_rollback_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      start && !busy && op_i == ksrl_pkg::OP_ROLLBACK |=> done_o && !busy)
    else $error("rollback word did not answer in one cycle");

  a_add_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
      start && !busy && op_i == ksrl_pkg::OP_ADD |=> busy && !done_o)
    else $error("add word did not start a scan");

  a_scan_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $fell(busy) |-> done_o && (status_o == ksrl_pkg::ST_PRESENT ||
                                 status_o == ksrl_pkg::ST_ADDED ||
                                 status_o == ksrl_pkg::ST_REFUSED))
    else $error("scan ended without an add result");
`endif

endmodule

// ----- sv/ksrl_log_mem.sv -----
// Key log storage: single write port, single registered read port.
// No dependencies.
module ksrl_log_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ksrl_ctrl.sv -----
// Sequencer and shared key comparator: scans the live log one entry per
// cycle, appends on miss if not full, handles rollback. Depends on ksrl_pkg.
module ksrl_ctrl #(
  parameter int unsigned LOG_DEPTH = ksrl_pkg::LOG_DEPTH_DEF,
  parameter int unsigned KEY_BITS  = ksrl_pkg::KEY_BITS_DEF,
  parameter int unsigned AW        = 8,
  parameter int unsigned CNT_W     = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [ksrl_pkg::KEY_W-1:0]  key_i,
  input  logic [ksrl_pkg::MARK_W-1:0] mark_i,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [KEY_BITS-1:0]         mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [KEY_BITS-1:0]         mem_rdata_i,
  output ksrl_pkg::result_t           res_o
);

  localparam int unsigned CMP_W =
      (CNT_W > ksrl_pkg::MARK_W) ? CNT_W : ksrl_pkg::MARK_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                rv_q, rv_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  ksrl_pkg::result_t   res_q, res_d;

  logic             hit;
  logic [CMP_W-1:0] mark_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_d_ext;

  assign hit       = rv_q && (mem_rdata_i == key_q);
  assign mark_ext  = CMP_W'(mark_i);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign cnt_d_ext = CMP_W'(cnt_d);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    rv_d         = 1'b0;
    key_d        = key_q;
    res_d        = res_q;
    res_d.done   = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cnt_q[AW-1:0];
    mem_wdata_o  = key_q;
    mem_re_o     = 1'b0;
    mem_raddr_o  = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (op_i == ksrl_pkg::OP_ADD) begin
            key_d   = key_i[KEY_BITS-1:0];
            idx_d   = '0;
            state_d = S_SCAN;
          end else begin
            res_d.done = 1'b1;
            if (mark_ext > cnt_ext) begin
              res_d.status = ksrl_pkg::ST_REFUSED;
            end else begin
              cnt_d        = mark_ext[CNT_W-1:0];
              res_d.status = ksrl_pkg::ST_ROLLED;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_d.done   = 1'b1;
          res_d.status = ksrl_pkg::ST_PRESENT;
          state_d      = S_IDLE;
        end else if (idx_q == cnt_q && !rv_q) begin
          res_d.done = 1'b1;
          state_d    = S_IDLE;
          if (cnt_q == DEPTH_CNT) begin
            res_d.status = ksrl_pkg::ST_REFUSED;
          end else begin
            mem_we_o     = 1'b1;
            cnt_d        = cnt_q + 1'b1;
            res_d.status = ksrl_pkg::ST_ADDED;
          end
        end else if (idx_q != cnt_q) begin
          mem_re_o = 1'b1;
          rv_d     = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count = cnt_d_ext[ksrl_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      rv_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign busy  = (state_q != S_IDLE);
  assign res_o = res_q;

endmodule

// ----- tb/sv/key_set_with_rollback_log_tb.sv -----
// Testbench for key_set_with_rollback_log: a clocked driver and monitor around
// a cycle-free prediction of the key log; checks every result word in order.
// Depends on ksrl_pkg and key_set_with_rollback_log.
module key_set_with_rollback_log_tb;

  localparam int unsigned LOG_ENTRIES = ksrl_pkg::LOG_DEPTH_DEF;
  localparam logic [ksrl_pkg::KEY_W-1:0] KEY_MASK =
      {ksrl_pkg::KEY_W{1'b1}} >> (ksrl_pkg::KEY_W - ksrl_pkg::KEY_BITS_DEF);
  localparam int unsigned RANDOM_WORDS = 1200;

  typedef struct packed {
    logic [LOG_ENTRIES-1:0][ksrl_pkg::KEY_W-1:0] keys;
    logic [31:0]                                 live;
  } key_log_t;

  typedef struct packed {
    logic                        op;
    logic [ksrl_pkg::KEY_W-1:0]  key;
    logic [ksrl_pkg::MARK_W-1:0] mark;
  } set_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [ksrl_pkg::COUNT_W-1:0] count;
  } set_answer_t;

  logic                         clk_i  = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start  = 1'b0;
  logic                         op_i   = ksrl_pkg::OP_ADD;
  logic [ksrl_pkg::KEY_W-1:0]   key_i  = '0;
  logic [ksrl_pkg::MARK_W-1:0]  mark_i = '0;
  logic                         busy;
  logic                         done_o;
  logic [1:0]                   status_o;
  logic [ksrl_pkg::COUNT_W-1:0] count_o;

  key_log_t    plan_log;
  key_log_t    live_log;
  set_word_t   words_todo[$];
  set_answer_t answers_due[$];
  int unsigned words_taken;
  int unsigned fail_count;
  bit          idle_now;

  key_set_with_rollback_log i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .op_i    (op_i),
    .key_i   (key_i),
    .mark_i  (mark_i),
    .done_o  (done_o),
    .status_o(status_o),
    .count_o (count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic apply_word(inout key_log_t s, input set_word_t w, output set_answer_t a);
    logic [ksrl_pkg::KEY_W-1:0] k;
    bit                         hit;
    k   = w.key & KEY_MASK;
    hit = 1'b0;
    if (w.op == ksrl_pkg::OP_ADD) begin
      for (int i = 0; i < s.live; i++) begin
        if (s.keys[i] == k) hit = 1'b1;
      end
      if (hit) begin
        a.status = ksrl_pkg::ST_PRESENT;
      end else if (s.live >= LOG_ENTRIES) begin
        a.status = ksrl_pkg::ST_REFUSED;
      end else begin
        s.keys[s.live] = k;
        s.live         = s.live + 1;
        a.status       = ksrl_pkg::ST_ADDED;
      end
    end else if (w.mark > s.live) begin
      a.status = ksrl_pkg::ST_REFUSED;
    end else begin
      s.live   = 32'(w.mark);
      a.status = ksrl_pkg::ST_ROLLED;
    end
    a.count = s.live[ksrl_pkg::COUNT_W-1:0];
  endtask

  task automatic push_word(input logic op, input logic [ksrl_pkg::KEY_W-1:0] key,
                           input logic [ksrl_pkg::MARK_W-1:0] mark);
    set_word_t   w;
    set_answer_t a;
    w = '{op: op, key: key, mark: mark};
    apply_word(plan_log, w, a);
    words_todo.push_back(w);
  endtask

  function automatic logic [ksrl_pkg::KEY_W-1:0] any_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ksrl_pkg::KEY_W-1:0] live_pick();
    if (plan_log.live == 0) return any_key();
    return plan_log.keys[$urandom_range(plan_log.live - 1, 0)];
  endfunction

  // driver: a word stays on the ports until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        set_answer_t a;
        apply_word(live_log, '{op: op_i, key: key_i, mark: mark_i}, a);
        answers_due.push_back(a);
        words_taken = words_taken + 1;
      end
      if (!start || !busy) begin
        idle_now = (words_taken < 300 || words_taken > 550) && ($urandom_range(99, 0) < 36);
        if (words_todo.size() > 0 && !idle_now) begin
          set_word_t w;
          w = words_todo.pop_front();
          op_i   <= w.op;
          key_i  <= w.key;
          mark_i <= w.mark;
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("unexpected result word: status %0d count %0d", status_o, count_o);
      end else begin
        set_answer_t e;
        e = answers_due.pop_front();
        if (status_o !== e.status || count_o !== e.count) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                     e.status, status_o, e.count, count_o);
        end
      end
    end
  end

  initial begin
    int unsigned fills;
    int unsigned pick;
    int unsigned n;
    int unsigned target;
    plan_log    = '0;
    live_log    = '0;
    words_taken = 0;
    fail_count  = 0;
    fills       = 0;

    // directed: empty-log rollbacks, extreme keys, repeats, marks around count
    push_word(ksrl_pkg::OP_ROLLBACK, '0, 9'd0);
    push_word(ksrl_pkg::OP_ROLLBACK, '0, 9'd1);
    push_word(ksrl_pkg::OP_ROLLBACK, '1, 9'd256);
    push_word(ksrl_pkg::OP_ADD, '0, '0);
    push_word(ksrl_pkg::OP_ADD, '1, '0);
    push_word(ksrl_pkg::OP_ADD, '0, '1);
    push_word(ksrl_pkg::OP_ADD, 64'h8000_0000_0000_0000, '0);
    push_word(ksrl_pkg::OP_ADD, 64'h0000_0000_0000_0001, '1);
    push_word(ksrl_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    push_word(ksrl_pkg::OP_ADD, 64'h5555_5555_5555_5555, '0);
    push_word(ksrl_pkg::OP_ADD, '1, '0);
    push_word(ksrl_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    push_word(ksrl_pkg::OP_ROLLBACK, '0, 9'd7);
    push_word(ksrl_pkg::OP_ROLLBACK, '0, 9'd8);
    push_word(ksrl_pkg::OP_ROLLBACK, '1, 9'd2);
    push_word(ksrl_pkg::OP_ADD, 64'h8000_0000_0000_0000, '0);
    push_word(ksrl_pkg::OP_ADD, '1, '0);
    push_word(ksrl_pkg::OP_ROLLBACK, '0, 9'd0);
    push_word(ksrl_pkg::OP_ADD, '1, '0);

    target = words_todo.size() + RANDOM_WORDS;
    while (words_todo.size() < target) begin
      pick = $urandom_range(99, 0);
      if (fills == 0 || (pick < 3 && fills < 2)) begin
        // fill the log, then poke it while full
        fills = fills + 1;
        while (plan_log.live < LOG_ENTRIES) push_word(ksrl_pkg::OP_ADD, any_key(), '0);
        push_word(ksrl_pkg::OP_ADD, live_pick(), '0);
        push_word(ksrl_pkg::OP_ADD, any_key(), '0);
        push_word(ksrl_pkg::OP_ADD,
                  live_pick() ^ (64'd1 << $urandom_range(ksrl_pkg::KEY_W - 1, 0)), '0);
        push_word(ksrl_pkg::OP_ADD, plan_log.keys[LOG_ENTRIES - 1], '0);
        push_word(ksrl_pkg::OP_ROLLBACK, any_key(), 9'd256);
        push_word(ksrl_pkg::OP_ADD, any_key(), '0);
        push_word(ksrl_pkg::OP_ROLLBACK, any_key(),
                  ksrl_pkg::MARK_W'($urandom_range(LOG_ENTRIES, 0)));
      end else if (pick < 85) begin
        n = $urandom_range(20, 5);
        repeat (n) begin
          pick = $urandom_range(99, 0);
          if (pick < 55)
            push_word(ksrl_pkg::OP_ADD, any_key(), ksrl_pkg::MARK_W'($urandom));
          else if (pick < 80)
            push_word(ksrl_pkg::OP_ADD, live_pick(), ksrl_pkg::MARK_W'($urandom));
          else if (pick < 90)
            push_word(ksrl_pkg::OP_ADD,
                      live_pick() ^ (64'd1 << $urandom_range(ksrl_pkg::KEY_W - 1, 0)),
                      ksrl_pkg::MARK_W'($urandom));
          else
            push_word(ksrl_pkg::OP_ROLLBACK, any_key(),
                      ksrl_pkg::MARK_W'($urandom_range(plan_log.live, 0)));
        end
      end else begin
        push_word(1'($urandom), any_key(),
                  ksrl_pkg::MARK_W'($urandom_range(LOG_ENTRIES, 0)));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_todo.size() != 0 || start || answers_due.size() != 0) @(posedge clk_i);
    repeat (LOG_ENTRIES + 8) @(posedge clk_i);
    if (answers_due.size() != 0) fail_count = fail_count + 1;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
